/* rtl/bst_pkg.sv */
// Shared types, constants and keyword tables for the BASIC source tokenizer.
package bst_pkg;

  localparam int WORD_BUFFER_LEN = 11;
  localparam int MANTISSA_BITS   = 48;
  localparam int MANT_W          = 48;
  localparam int KW_MAX_LEN      = 11;
  localparam int WCNT_W          = $clog2(WORD_BUFFER_LEN + 2);
  localparam int WIDX_W          = $clog2(WORD_BUFFER_LEN);

  localparam logic [MANTISSA_BITS-1:0] MANT_MAX = '1;

  // token kinds
  localparam logic [6:0] K_END    = 7'd0;
  localparam logic [6:0] K_NUM    = 7'd1;
  localparam logic [6:0] K_STR    = 7'd2;
  localparam logic [6:0] K_MOD    = 7'd7;
  localparam logic [6:0] K_ID     = 7'd62;
  localparam logic [6:0] K_PLUS   = 7'd63;
  localparam logic [6:0] K_MINUS  = 7'd64;
  localparam logic [6:0] K_STAR   = 7'd65;
  localparam logic [6:0] K_SLASH  = 7'd66;
  localparam logic [6:0] K_EQEQ   = 7'd67;
  localparam logic [6:0] K_EQ     = 7'd68;
  localparam logic [6:0] K_LE     = 7'd69;
  localparam logic [6:0] K_NE     = 7'd70;
  localparam logic [6:0] K_SHL    = 7'd71;
  localparam logic [6:0] K_LT     = 7'd72;
  localparam logic [6:0] K_GE     = 7'd73;
  localparam logic [6:0] K_SHR    = 7'd74;
  localparam logic [6:0] K_GT     = 7'd75;
  localparam logic [6:0] K_SEMI   = 7'd76;
  localparam logic [6:0] K_COMMA  = 7'd77;
  localparam logic [6:0] K_LPAREN = 7'd78;
  localparam logic [6:0] K_RPAREN = 7'd79;
  localparam logic [6:0] K_DOT    = 7'd80;
  localparam logic [6:0] K_AMP    = 7'd81;

  // error codes
  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_UNTERM  = 2'd1;
  localparam logic [1:0] E_BAD_END = 2'd2;
  localparam logic [1:0] E_BAD_CH  = 2'd3;

  // characters
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_AMP    = 8'h26;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOI  = 1'b1;

  typedef enum logic [11:0] {
    M_IDLE    = 12'b0000_0000_0001,
    M_INT     = 12'b0000_0000_0010,
    M_FRAC    = 12'b0000_0000_0100,
    M_STR     = 12'b0000_0000_1000,
    M_WORD    = 12'b0000_0001_0000,
    M_GAP     = 12'b0000_0010_0000,
    M_WORD2   = 12'b0000_0100_0000,
    M_COMMENT = 12'b0000_1000_0000,
    M_EQ      = 12'b0001_0000_0000,
    M_LT      = 12'b0010_0000_0000,
    M_GT      = 12'b0100_0000_0000,
    M_HALT    = 12'b1000_0000_0000
  } mode_t;

  typedef logic [WORD_BUFFER_LEN-1:0][6:0] wbuf_t;

  typedef struct packed {
    logic [6:0]        kind;
    logic [1:0]        error_code;
    logic [15:0]       line_no;
    logic [31:0]       start_offset;
    logic [15:0]       lexeme_length;
    logic [MANT_W-1:0] mantissa;
    logic [7:0]        frac_digits;
    logic              is_final;
    logic              last;
  } res_t;

  // results of one accepted word, in order
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

  typedef struct packed {
    logic [8*KW_MAX_LEN-1:0] txt;
    logic [3:0]              len;
    logic [6:0]              kind;
  } kw_t;

  localparam int NUM_KW  = 59;
  localparam int NUM_END = 6;

  localparam kw_t KW_TABLE [NUM_KW] = '{
    '{"PRINT", 4'd5, 7'd3}, '{"LET", 4'd3, 7'd4}, '{"INPUT", 4'd5, 7'd5},
    '{"DIM", 4'd3, 7'd6}, '{"MOD", 4'd3, 7'd7}, '{"IF", 4'd2, 7'd8},
    '{"THEN", 4'd4, 7'd9}, '{"ELSE", 4'd4, 7'd10}, '{"ELSEIF", 4'd6, 7'd11},
    '{"ENDIF", 4'd5, 7'd12}, '{"FOR", 4'd3, 7'd13}, '{"TO", 4'd2, 7'd14},
    '{"STEP", 4'd4, 7'd15}, '{"NEXT", 4'd4, 7'd16}, '{"WHILE", 4'd5, 7'd17},
    '{"ENDWHILE", 4'd8, 7'd18}, '{"WEND", 4'd4, 7'd19}, '{"DO", 4'd2, 7'd20},
    '{"UNTIL", 4'd5, 7'd21}, '{"ENDFUNCTION", 4'd11, 7'd22},
    '{"ENDSUB", 4'd6, 7'd23}, '{"ENDTYPE", 4'd7, 7'd24},
    '{"ENDCLASS", 4'd8, 7'd25}, '{"FUNCTION", 4'd8, 7'd26},
    '{"SUB", 4'd3, 7'd27}, '{"RETURN", 4'd6, 7'd28}, '{"CALL", 4'd4, 7'd29},
    '{"TYPE", 4'd4, 7'd30}, '{"AS", 4'd2, 7'd31}, '{"CLASS", 4'd5, 7'd32},
    '{"PUBLIC", 4'd6, 7'd33}, '{"PRIVATE", 4'd7, 7'd34}, '{"NEW", 4'd3, 7'd35},
    '{"ME", 4'd2, 7'd36}, '{"INTEGER", 4'd7, 7'd37}, '{"AND", 4'd3, 7'd38},
    '{"OR", 4'd2, 7'd39}, '{"NOT", 4'd3, 7'd40}, '{"XOR", 4'd3, 7'd41},
    '{"EXIT", 4'd4, 7'd42}, '{"CONTINUE", 4'd8, 7'd43},
    '{"SELECT", 4'd6, 7'd44}, '{"CASE", 4'd4, 7'd45},
    '{"SINGLE", 4'd6, 7'd46}, '{"DOUBLE", 4'd6, 7'd47}, '{"LONG", 4'd4, 7'd48},
    '{"BOOLEAN", 4'd7, 7'd49}, '{"STRING", 4'd6, 7'd50},
    '{"DECIMAL", 4'd7, 7'd51}, '{"BIGINT", 4'd6, 7'd52},
    '{"CONSOLE", 4'd7, 7'd53}, '{"IMPORT", 4'd6, 7'd54},
    '{"IMPORTS", 4'd7, 7'd55}, '{"SHARED", 4'd6, 7'd56},
    '{"STATIC", 4'd6, 7'd57}, '{"BYVAL", 4'd5, 7'd58}, '{"BYREF", 4'd5, 7'd59},
    '{"TRUE", 4'd4, 7'd60}, '{"FALSE", 4'd5, 7'd61}
  };

  localparam kw_t END_TABLE [NUM_END] = '{
    '{"IF", 4'd2, 7'd12}, '{"SUB", 4'd3, 7'd23}, '{"FUNCTION", 4'd8, 7'd22},
    '{"TYPE", 4'd4, 7'd24}, '{"CLASS", 4'd5, 7'd25}, '{"WHILE", 4'd5, 7'd18}
  };

  localparam kw_t REM_WORD = '{"REM", 4'd3, 7'd0};
  localparam kw_t END_WORD = '{"END", 4'd3, 7'd0};

  function automatic logic word_eq(wbuf_t buf_w, logic [WCNT_W-1:0] cnt, kw_t e);
    logic hit;
    hit = (cnt == WCNT_W'(e.len));
    for (int i = 0; i < KW_MAX_LEN; i++) begin
      if (i < int'(e.len) && buf_w[i] != e.txt[8*(int'(e.len)-1-i) +: 7]) hit = 1'b0;
    end
    return hit;
  endfunction

  // keywords are all distinct, so at most one entry hits; 0 means no match
  function automatic logic [6:0] kw_lookup(wbuf_t buf_w, logic [WCNT_W-1:0] cnt);
    logic [6:0] k;
    k = '0;
    for (int i = 0; i < NUM_KW; i++) begin
      if (word_eq(buf_w, cnt, KW_TABLE[i])) k = k | KW_TABLE[i].kind;
    end
    return k;
  endfunction

  function automatic logic [6:0] end_lookup(wbuf_t buf_w, logic [WCNT_W-1:0] cnt);
    logic [6:0] k;
    k = '0;
    for (int i = 0; i < NUM_END; i++) begin
      if (word_eq(buf_w, cnt, END_TABLE[i])) k = k | END_TABLE[i].kind;
    end
    return k;
  endfunction

  function automatic res_t mk_res(logic [6:0] kind, logic [1:0] err, logic [15:0] line,
                                  logic [31:0] start, logic [15:0] len,
                                  logic [MANT_W-1:0] mant, logic [7:0] frac, logic fin);
    res_t r;
    r.kind          = kind;
    r.error_code    = err;
    r.line_no       = line;
    r.start_offset  = start;
    r.lexeme_length = len;
    r.mantissa      = mant;
    r.frac_digits   = frac;
    r.is_final      = fin;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/bst_if.sv */
// Handshake channel interfaces for source bytes and tokens.
interface bst_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] ch;
  modport source (output valid, cmd, ch, input ready);
  modport sink (input valid, cmd, ch, output ready);
endinterface

interface bst_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  kind;
  logic [1:0]  error_code;
  logic [15:0] line_no;
  logic [31:0] start_offset;
  logic [15:0] lexeme_length;
  logic [47:0] mantissa;
  logic [7:0]  frac_digits;
  logic        is_final;
  logic        last;
  modport source (output valid, kind, error_code, line_no, start_offset, lexeme_length,
                  mantissa, frac_digits, is_final, last, input ready);
  modport sink (input valid, kind, error_code, line_no, start_offset, lexeme_length,
                mantissa, frac_digits, is_final, last, output ready);
endinterface

/* rtl/bst_lexer.sv */
// Lexer state machine: one source word per cycle while take is high, up to two tokens out.
module bst_lexer
  import bst_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  take,
  input  logic  cmd,
  input  logic  [7:0] ch,
  output push_t push
);

  mode_t                    mode_r, mode_nxt;
  wbuf_t                    buf_r, buf_nxt;
  logic [WCNT_W-1:0]        wcnt_r, wcnt_nxt;
  logic [MANTISSA_BITS-1:0] acc_r, acc_nxt;
  logic [7:0]               frac_r, frac_nxt;
  logic [15:0]              line_r, line_nxt;
  logic [31:0]              pos_r, pos_nxt;
  logic [31:0]              tstart_r, tstart_nxt;
  logic [15:0]              tline_r, tline_nxt;
  logic [15:0]              span_r, span_nxt;

  logic is_ws, is_dig, is_alpha, is_alnum;
  logic [6:0] up_c;
  logic [15:0] line_new, span_p1;
  logic [MANTISSA_BITS+3:0] dsum;
  logic [MANTISSA_BITS-1:0] acc_dig;
  logic [6:0] kw_kind, end_kind;
  logic is_rem, is_end;

  res_t ra, rb;
  logic has_a, has_b, redo;

  assign is_ws    = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
  assign is_dig   = (ch >= 8'h30 && ch <= 8'h39);
  assign is_alpha = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
  assign is_alnum = is_alpha || is_dig;
  assign up_c     = (ch >= 8'h61 && ch <= 8'h7A) ? 7'(ch - 8'd32) : ch[6:0];
  assign line_new = (ch == CH_LF && line_r != 16'hFFFF) ? line_r + 16'd1 : line_r;
  assign span_p1  = (span_r == 16'hFFFF) ? span_r : span_r + 16'd1;

  // acc*10 + d, saturated at the mantissa limit
  assign dsum    = (MANTISSA_BITS+4)'(acc_r) * (MANTISSA_BITS+4)'(10)
                 + (MANTISSA_BITS+4)'(ch[3:0]);
  assign acc_dig = (dsum > (MANTISSA_BITS+4)'(MANT_MAX)) ? MANT_MAX
                                                         : dsum[MANTISSA_BITS-1:0];

  assign kw_kind  = kw_lookup(buf_r, wcnt_r);
  assign end_kind = end_lookup(buf_r, wcnt_r);
  assign is_rem   = word_eq(buf_r, wcnt_r, REM_WORD);
  assign is_end   = word_eq(buf_r, wcnt_r, END_WORD);

  always_comb begin
    mode_nxt   = mode_r;
    buf_nxt    = buf_r;
    wcnt_nxt   = wcnt_r;
    acc_nxt    = acc_r;
    frac_nxt   = frac_r;
    line_nxt   = line_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    tline_nxt  = tline_r;
    span_nxt   = span_r;
    ra         = '0;
    rb         = '0;
    has_a      = 1'b0;
    has_b      = 1'b0;
    redo       = 1'b0;

    if (take && mode_r != M_HALT) begin
      if (cmd == CMD_EOI) begin
        mode_nxt = M_HALT;
        has_b    = 1'b1;
        rb = mk_res(K_END, E_NONE, line_r, pos_r, 16'd0, '0, 8'd0, 1'b1);
        case (mode_r)
          M_INT, M_FRAC: begin
            has_a = 1'b1;
            ra = mk_res(K_NUM, E_NONE, tline_r, tstart_r, span_r, MANT_W'(acc_r), frac_r,
                        1'b0);
          end
          M_STR: begin
            has_a = 1'b1;
            has_b = 1'b0;
            ra = mk_res(K_END, E_UNTERM, tline_r, tstart_r, span_r, '0, 8'd0, 1'b1);
          end
          M_WORD: begin
            if (!is_rem) begin
              has_a = 1'b1;
              ra = mk_res(is_end ? K_END : (kw_kind != 7'd0 ? kw_kind : K_ID), E_NONE,
                          tline_r, tstart_r, is_end ? 16'd3 : span_r, '0, 8'd0, 1'b0);
            end
          end
          M_GAP: begin
            has_a = 1'b1;
            ra = mk_res(K_END, E_NONE, tline_r, tstart_r, 16'd3, '0, 8'd0, 1'b0);
          end
          M_WORD2: begin
            has_a = 1'b1;
            if (end_kind == 7'd0) begin
              has_b = 1'b0;
              ra = mk_res(K_END, E_BAD_END, tline_r, tstart_r, span_r, '0, 8'd0, 1'b1);
            end else begin
              ra = mk_res(end_kind, E_NONE, tline_r, tstart_r, span_r, '0, 8'd0, 1'b0);
            end
          end
          M_EQ: begin
            has_a = 1'b1;
            ra = mk_res(K_EQ, E_NONE, tline_r, tstart_r, 16'd1, '0, 8'd0, 1'b0);
          end
          M_LT: begin
            has_a = 1'b1;
            ra = mk_res(K_LT, E_NONE, tline_r, tstart_r, 16'd1, '0, 8'd0, 1'b0);
          end
          M_GT: begin
            has_a = 1'b1;
            ra = mk_res(K_GT, E_NONE, tline_r, tstart_r, 16'd1, '0, 8'd0, 1'b0);
          end
          default: ;
        endcase
      end else begin
        line_nxt = line_new;
        pos_nxt  = pos_r + 32'd1;
        case (mode_r)
          M_IDLE: redo = 1'b1;
          M_INT: begin
            if (is_dig) begin
              acc_nxt  = acc_dig;
              span_nxt = span_p1;
            end else if (ch == CH_DOT) begin
              span_nxt = span_p1;
              mode_nxt = M_FRAC;
            end else begin
              has_a = 1'b1;
              redo  = 1'b1;
              ra = mk_res(K_NUM, E_NONE, tline_r, tstart_r, span_r, MANT_W'(acc_r), frac_r,
                          1'b0);
            end
          end
          M_FRAC: begin
            if (is_dig) begin
              acc_nxt  = acc_dig;
              span_nxt = span_p1;
              if (frac_r != 8'hFF) frac_nxt = frac_r + 8'd1;
            end else begin
              has_a = 1'b1;
              redo  = 1'b1;
              ra = mk_res(K_NUM, E_NONE, tline_r, tstart_r, span_r, MANT_W'(acc_r), frac_r,
                          1'b0);
            end
          end
          M_STR: begin
            if (ch == CH_QUOTE) begin
              has_a    = 1'b1;
              mode_nxt = M_IDLE;
              ra = mk_res(K_STR, E_NONE, tline_r, tstart_r, span_r, '0, 8'd0, 1'b0);
            end else begin
              span_nxt = span_p1;
            end
          end
          M_WORD, M_WORD2: begin
            if (is_alnum) begin
              if (wcnt_r < WCNT_W'(WORD_BUFFER_LEN)) buf_nxt[wcnt_r[WIDX_W-1:0]] = up_c;
              if (wcnt_r <= WCNT_W'(WORD_BUFFER_LEN)) wcnt_nxt = wcnt_r + WCNT_W'(1);
              span_nxt = span_p1;
            end else if (mode_r == M_WORD2) begin
              has_a = 1'b1;
              if (end_kind == 7'd0) begin
                mode_nxt = M_HALT;
                ra = mk_res(K_END, E_BAD_END, tline_r, tstart_r, span_r, '0, 8'd0, 1'b1);
              end else begin
                redo = 1'b1;
                ra = mk_res(end_kind, E_NONE, tline_r, tstart_r, span_r, '0, 8'd0, 1'b0);
              end
            end else if (is_rem) begin
              // REM ended by a newline closes the comment at once
              mode_nxt = (ch == CH_LF) ? M_IDLE : M_COMMENT;
            end else if (is_end) begin
              if (is_ws) begin
                span_nxt = span_p1;
                mode_nxt = M_GAP;
              end else begin
                has_a = 1'b1;
                redo  = 1'b1;
                ra = mk_res(K_END, E_NONE, tline_r, tstart_r, 16'd3, '0, 8'd0, 1'b0);
              end
            end else begin
              has_a = 1'b1;
              redo  = 1'b1;
              ra = mk_res(kw_kind != 7'd0 ? kw_kind : K_ID, E_NONE, tline_r, tstart_r,
                          span_r, '0, 8'd0, 1'b0);
            end
          end
          M_GAP: begin
            if (is_ws) begin
              span_nxt = span_p1;
            end else if (is_alpha) begin
              buf_nxt[0] = up_c;
              wcnt_nxt   = WCNT_W'(1);
              span_nxt   = span_p1;
              mode_nxt   = M_WORD2;
            end else begin
              has_a = 1'b1;
              redo  = 1'b1;
              ra = mk_res(K_END, E_NONE, tline_r, tstart_r, 16'd3, '0, 8'd0, 1'b0);
            end
          end
          M_COMMENT: begin
            if (ch == CH_LF) mode_nxt = M_IDLE;
          end
          M_EQ: begin
            has_a    = 1'b1;
            mode_nxt = M_IDLE;
            if (ch == CH_EQ) begin
              ra = mk_res(K_EQEQ, E_NONE, tline_r, tstart_r, 16'd2, '0, 8'd0, 1'b0);
            end else begin
              redo = 1'b1;
              ra = mk_res(K_EQ, E_NONE, tline_r, tstart_r, 16'd1, '0, 8'd0, 1'b0);
            end
          end
          M_LT: begin
            has_a    = 1'b1;
            mode_nxt = M_IDLE;
            if (ch == CH_EQ) begin
              ra = mk_res(K_LE, E_NONE, tline_r, tstart_r, 16'd2, '0, 8'd0, 1'b0);
            end else if (ch == CH_GT) begin
              ra = mk_res(K_NE, E_NONE, tline_r, tstart_r, 16'd2, '0, 8'd0, 1'b0);
            end else if (ch == CH_LT) begin
              ra = mk_res(K_SHL, E_NONE, tline_r, tstart_r, 16'd2, '0, 8'd0, 1'b0);
            end else begin
              redo = 1'b1;
              ra = mk_res(K_LT, E_NONE, tline_r, tstart_r, 16'd1, '0, 8'd0, 1'b0);
            end
          end
          M_GT: begin
            has_a    = 1'b1;
            mode_nxt = M_IDLE;
            if (ch == CH_EQ) begin
              ra = mk_res(K_GE, E_NONE, tline_r, tstart_r, 16'd2, '0, 8'd0, 1'b0);
            end else if (ch == CH_GT) begin
              ra = mk_res(K_SHR, E_NONE, tline_r, tstart_r, 16'd2, '0, 8'd0, 1'b0);
            end else begin
              redo = 1'b1;
              ra = mk_res(K_GT, E_NONE, tline_r, tstart_r, 16'd1, '0, 8'd0, 1'b0);
            end
          end
          default: mode_nxt = M_HALT;
        endcase

        // byte handled from the idle state, or seen again there after the token it closed
        if (redo) begin
          mode_nxt   = M_IDLE;
          tstart_nxt = pos_r;
          tline_nxt  = line_new;
          span_nxt   = 16'd1;
          if (is_ws) begin
            tstart_nxt = tstart_r;
            tline_nxt  = tline_r;
            span_nxt   = span_r;
          end else if (is_dig) begin
            mode_nxt = M_INT;
            acc_nxt  = MANTISSA_BITS'(ch[3:0]);
            frac_nxt = 8'd0;
          end else if (is_alpha) begin
            mode_nxt   = M_WORD;
            buf_nxt[0] = up_c;
            wcnt_nxt   = WCNT_W'(1);
          end else if (ch == CH_QUOTE) begin
            mode_nxt   = M_STR;
            tstart_nxt = pos_r + 32'd1;
            span_nxt   = 16'd0;
          end else if (ch == CH_EQ) begin
            mode_nxt = M_EQ;
          end else if (ch == CH_LT) begin
            mode_nxt = M_LT;
          end else if (ch == CH_GT) begin
            mode_nxt = M_GT;
          end else if (ch == CH_APOS) begin
            mode_nxt   = M_COMMENT;
            tstart_nxt = tstart_r;
            tline_nxt  = tline_r;
            span_nxt   = span_r;
          end else begin
            has_b = 1'b1;
            rb = mk_res(K_PLUS, E_NONE, line_new, pos_r, 16'd1, '0, 8'd0, 1'b0);
            case (ch)
              CH_PLUS:   rb.kind = K_PLUS;
              CH_MINUS:  rb.kind = K_MINUS;
              CH_STAR:   rb.kind = K_STAR;
              CH_SLASH:  rb.kind = K_SLASH;
              CH_PCT:    rb.kind = K_MOD;
              CH_SEMI:   rb.kind = K_SEMI;
              CH_COMMA:  rb.kind = K_COMMA;
              CH_LPAREN: rb.kind = K_LPAREN;
              CH_RPAREN: rb.kind = K_RPAREN;
              CH_DOT:    rb.kind = K_DOT;
              CH_AMP:    rb.kind = K_AMP;
              default: begin
                rb.kind       = K_END;
                rb.error_code = E_BAD_CH;
                rb.is_final   = 1'b1;
                mode_nxt      = M_HALT;
              end
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    push.cnt    = 2'(has_a) + 2'(has_b);
    push.first  = has_a ? ra : rb;
    push.second = rb;
    push.first.last  = (push.cnt == 2'd1);
    push.second.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      wcnt_r   <= '0;
      acc_r    <= '0;
      frac_r   <= '0;
      line_r   <= 16'd1;
      pos_r    <= '0;
      tstart_r <= '0;
      tline_r  <= 16'd1;
      span_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      wcnt_r   <= wcnt_nxt;
      acc_r    <= acc_nxt;
      frac_r   <= frac_nxt;
      line_r   <= line_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      tline_r  <= tline_nxt;
      span_r   <= span_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

/* rtl/bst_outq.sv */
// Four-entry token queue: takes up to two tokens a cycle, gives one while out_ready is high.
module bst_outq
  import bst_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  space2,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  res_t       mem_r [4];
  logic [1:0] wr_r, rd_r;
  logic [2:0] cnt_r;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_res   = mem_r[rd_r];
  assign space2    = (cnt_r <= 3'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + push.cnt;
      rd_r  <= rd_r + 2'(pop);
      cnt_r <= cnt_r + 3'(push.cnt) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_r] <= push.first;
    if (push.cnt == 2'd2) mem_r[wr_r + 2'd1] <= push.second;
  end

endmodule

/* rtl/basic_source_tokenizer.sv */
// Top level of the streaming BASIC source tokenizer.
//
// in_ch carries one source byte per word (cmd = 0) or the end mark (cmd = 1).
// out_ch carries tokens: kind, line, start offset, length, and for numbers a
// decimal mantissa with a count of fraction digits. Each input word gives
// zero, one or two tokens; the last one of a word has last set.
// Throughput: one input word per cycle while the output side keeps up.
// A completed token is registered into the queue and shown on out_ch from the
// queue head; it waits there behind any older tokens.
// The lexer updates its state in the same cycle it takes a byte; tokens go
// into a four-entry queue, and in_ch.ready is high while the queue has room
// for two more, so a stalled receiver backs up into in_ch once three tokens wait.
// After an error token or the end-of-input token the block ignores further
// input (it still takes it) until reset.
// Reset (rst_n low, synchronous) returns to line 1, offset 0, between tokens,
// and empties the queue.
module basic_source_tokenizer
  import bst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bst_in_if.sink     in_ch,
  bst_out_if.source  out_ch
);

  push_t push;
  res_t  head;
  logic  space2;

  assign in_ch.ready = space2;

  bst_lexer u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (in_ch.valid && space2),
    .cmd   (in_ch.cmd),
    .ch    (in_ch.ch),
    .push  (push)
  );

  bst_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space2    (space2),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (head)
  );

  assign out_ch.kind          = head.kind;
  assign out_ch.error_code    = head.error_code;
  assign out_ch.line_no       = head.line_no;
  assign out_ch.start_offset  = head.start_offset;
  assign out_ch.lexeme_length = head.lexeme_length;
  assign out_ch.mantissa      = head.mantissa;
  assign out_ch.frac_digits   = head.frac_digits;
  assign out_ch.is_final      = head.is_final;
  assign out_ch.last          = head.last;

endmodule

/* rtl/bst_checker.sv */
// Port-level checks for the tokenizer, bound to the top level.
module bst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  error_code,
  input logic        is_final,
  input logic        last,
  input logic [31:0] start_offset
);

  // a held token keeps its start offset and last flag
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(start_offset) && $stable(last))
    else $error("stalled token changed");

  // the second token of a word is queued together with the first
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last |=> out_valid)
    else $error("second token of a word missing");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_final |-> last)
    else $error("final token not last");

  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_code != 2'd0 |-> is_final)
    else $error("error token not final");

  // after the final token is taken, out_valid goes low
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && is_final |=> !out_valid)
    else $error("token after final");

endmodule

bind basic_source_tokenizer bst_checker u_bst_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .error_code   (out_ch.error_code),
  .is_final     (out_ch.is_final),
  .last         (out_ch.last),
  .start_offset (out_ch.start_offset)
);
